FILE: rtl/pdab_pkg.sv
// Shared types, constants and divide helpers for the pixel depth/alpha blend block.
`default_nettype none

package pdab_pkg;

   localparam int DEPTH_BITS     = 24;
   localparam int COLOR_BITS     = 8;
   localparam int BRIGHT_BITS    = 15;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   // front end: test + alpha product, alpha divide
   localparam int FRONT_STAGES = 2;
   // channel: products, brightness product, /32767, sum, /255
   localparam int CHAN_STAGES  = 5;
   // front + channel + output register
   localparam int LATENCY      = FRONT_STAGES + CHAN_STAGES + 1;

   localparam logic [COLOR_BITS-1:0] ALPHA_FULL = 8'hFF;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEPTH_TEST_ON   = 2'd0,
      CSR_DEPTH_WRITE_OFF = 2'd1,
      CSR_GLOBAL_ALPHA    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  depth_test_on;
      logic                  depth_write_off;
      logic [COLOR_BITS-1:0] global_alpha;
   } cfg_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } rgb_type;

   // fields that ride alongside the channel math
   typedef struct packed {
      logic                  pass;
      logic [DEPTH_BITS-1:0] depth;
      rgb_type               dst;
   } meta_type;

   // x / 255 for x up to 65535: estimate low by at most one, then fix up
   function automatic logic [COLOR_BITS-1:0] div255(input logic [15:0] x);
      logic [16:0] t;
      logic [8:0]  q0;
      logic [16:0] r;
      logic [8:0]  q;
      t  = {1'b0, x} + {9'b0, x[15:8]};
      q0 = t[16:8];
      r  = {1'b0, x} - ({q0, 8'b0} - {8'b0, q0});
      q  = (r >= 17'd255) ? q0 + 9'd1 : q0;
      return q[COLOR_BITS-1:0];
   endfunction

   // y / 32767 for y below 2^31: same estimate and single correction
   function automatic logic [15:0] div32767(input logic [30:0] y);
      logic [31:0] t;
      logic [16:0] q0;
      logic [31:0] r;
      logic [16:0] q;
      t  = {1'b0, y} + {16'b0, y[30:15]};
      q0 = t[31:15];
      r  = {1'b0, y} - ({q0, 15'b0} - {15'b0, q0});
      q  = (r >= 32'd32767) ? q0 + 17'd1 : q0;
      return q[15:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pixel_depth_alpha_blend_top.sv
// Top level of the pixel depth test and alpha blend stage.
//
//   channel  ports                 handshake
//   request  start, busy, req_*    beat taken when start && !busy
//   result   rsp_strobe, rsp_*     one-cycle strobe, no back-pressure
//   csr      csr_valid/ready/...   write taken when csr_valid && csr_ready
//
// One fragment per clock; each result beat follows its request beat through every
// register stage of the datapath (front 2, channel 5, output 1). busy is always low
// and csr_ready always high; nothing ever stalls.
// Synchronous reset clears the valid pipeline and loads the csr defaults.
`default_nettype none

module pixel_depth_alpha_blend_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]       req_dst_red,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]       req_dst_green,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]       req_dst_blue,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]       req_src_red,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]       req_src_green,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]       req_src_blue,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]       req_src_alpha,
   input  wire logic [pdab_pkg::DEPTH_BITS-1:0]       req_stored_depth,
   input  wire logic [pdab_pkg::DEPTH_BITS-1:0]       req_frag_depth,
   input  wire logic [pdab_pkg::BRIGHT_BITS-1:0]      req_brightness,
   output logic                                       rsp_strobe,
   output logic [pdab_pkg::COLOR_BITS-1:0]            rsp_out_red,
   output logic [pdab_pkg::COLOR_BITS-1:0]            rsp_out_green,
   output logic [pdab_pkg::COLOR_BITS-1:0]            rsp_out_blue,
   output logic [pdab_pkg::DEPTH_BITS-1:0]            rsp_out_depth,
   output logic                                       rsp_color_written,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [pdab_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [pdab_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int N = pdab_pkg::CHAN_STAGES;

   pdab_pkg::cfg_type                   cfg_ff;
   pdab_pkg::rgb_type                   req_dst;
   pdab_pkg::rgb_type                   req_src;

   logic                                front_valid;
   pdab_pkg::meta_type                  front_meta;
   pdab_pkg::rgb_type                   front_src;
   logic [pdab_pkg::COLOR_BITS-1:0]     front_alpha;
   logic [pdab_pkg::BRIGHT_BITS-1:0]    front_bright;
   pdab_pkg::rgb_type                   mix;

   logic [N-1:0]                        pipe_valid_ff;
   pdab_pkg::meta_type                  meta_pipe_ff [N];
   pdab_pkg::meta_type                  meta_last;

   logic                                rsp_strobe_ff;
   pdab_pkg::rgb_type                   rsp_rgb_in;
   pdab_pkg::rgb_type                   rsp_rgb_ff;
   logic [pdab_pkg::DEPTH_BITS-1:0]     rsp_depth_ff;
   logic                                rsp_written_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_test_on   <= 1'b1;
         cfg_ff.depth_write_off <= 1'b0;
         cfg_ff.global_alpha    <= pdab_pkg::ALPHA_FULL;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pdab_pkg::CSR_DEPTH_TEST_ON:   cfg_ff.depth_test_on   <= csr_data[0];
            pdab_pkg::CSR_DEPTH_WRITE_OFF: cfg_ff.depth_write_off <= csr_data[0];
            pdab_pkg::CSR_GLOBAL_ALPHA:    cfg_ff.global_alpha    <= csr_data;
            default: ;  // drop writes past the register list
         endcase
      end
   end

   assign req_dst = '{red: req_dst_red, green: req_dst_green, blue: req_dst_blue};
   assign req_src = '{red: req_src_red, green: req_src_green, blue: req_src_blue};

   pdab_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .cfg          (cfg_ff),
      .dst          (req_dst),
      .src          (req_src),
      .src_alpha    (req_src_alpha),
      .stored_depth (req_stored_depth),
      .frag_depth   (req_frag_depth),
      .brightness   (req_brightness),
      .out_valid    (front_valid),
      .meta_out     (front_meta),
      .src_out      (front_src),
      .alpha_out    (front_alpha),
      .bright_out   (front_bright)
   );

   pdab_chan u_chan_red (
      .clock  (clock),
      .dst    (front_meta.dst.red),
      .src    (front_src.red),
      .alpha  (front_alpha),
      .bright (front_bright),
      .mix    (mix.red)
   );

   pdab_chan u_chan_green (
      .clock  (clock),
      .dst    (front_meta.dst.green),
      .src    (front_src.green),
      .alpha  (front_alpha),
      .bright (front_bright),
      .mix    (mix.green)
   );

   pdab_chan u_chan_blue (
      .clock  (clock),
      .dst    (front_meta.dst.blue),
      .src    (front_src.blue),
      .alpha  (front_alpha),
      .bright (front_bright),
      .mix    (mix.blue)
   );

   // carry pass flag, depth and dst color alongside the channel stages
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else begin
         pipe_valid_ff <= {pipe_valid_ff[N-2:0], front_valid};
      end
   end

   always_ff @(posedge clock) begin
      meta_pipe_ff[0] <= front_meta;
      for (int i = 1; i < N; i++) begin
         meta_pipe_ff[i] <= meta_pipe_ff[i-1];
      end
   end

   assign meta_last  = meta_pipe_ff[N-1];
   assign rsp_rgb_in = meta_last.pass ? mix : meta_last.dst;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= pipe_valid_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_rgb_ff     <= rsp_rgb_in;
      rsp_depth_ff   <= meta_last.depth;
      rsp_written_ff <= meta_last.pass;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_out_red       = rsp_rgb_ff.red;
   assign rsp_out_green     = rsp_rgb_ff.green;
   assign rsp_out_blue      = rsp_rgb_ff.blue;
   assign rsp_out_depth     = rsp_depth_ff;
   assign rsp_color_written = rsp_written_ff;

endmodule

`default_nettype wire

FILE: rtl/pdab_front.sv
// Front end: reject and depth decision, effective alpha.
`default_nettype none

module pdab_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire pdab_pkg::cfg_type                   cfg,
   input  wire pdab_pkg::rgb_type                   dst,
   input  wire pdab_pkg::rgb_type                   src,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]     src_alpha,
   input  wire logic [pdab_pkg::DEPTH_BITS-1:0]     stored_depth,
   input  wire logic [pdab_pkg::DEPTH_BITS-1:0]     frag_depth,
   input  wire logic [pdab_pkg::BRIGHT_BITS-1:0]    brightness,
   output logic                                     out_valid,
   output pdab_pkg::meta_type                       meta_out,
   output pdab_pkg::rgb_type                        src_out,
   output logic [pdab_pkg::COLOR_BITS-1:0]          alpha_out,
   output logic [pdab_pkg::BRIGHT_BITS-1:0]         bright_out
);

   logic                               pass_in;
   logic [pdab_pkg::DEPTH_BITS-1:0]    depth_in;
   logic [15:0]                        prod_in;

   logic                               s1_valid_ff;
   pdab_pkg::meta_type                 s1_meta_ff;
   pdab_pkg::rgb_type                  s1_src_ff;
   logic [pdab_pkg::BRIGHT_BITS-1:0]   s1_bright_ff;
   logic [15:0]                        s1_prod_ff;

   logic                               s2_valid_ff;
   pdab_pkg::meta_type                 s2_meta_ff;
   pdab_pkg::rgb_type                  s2_src_ff;
   logic [pdab_pkg::BRIGHT_BITS-1:0]   s2_bright_ff;
   logic [pdab_pkg::COLOR_BITS-1:0]    s2_alpha_ff;

   always_comb begin
      pass_in = (brightness != '0) && (src_alpha != '0) &&
                (!cfg.depth_test_on || (stored_depth > frag_depth));
      depth_in = (pass_in && cfg.depth_test_on && !cfg.depth_write_off) ?
                 frag_depth : stored_depth;
      prod_in = {8'b0, src_alpha} * {8'b0, cfg.global_alpha};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff.pass  <= pass_in;
      s1_meta_ff.depth <= depth_in;
      s1_meta_ff.dst   <= dst;
      s1_src_ff        <= src;
      s1_bright_ff     <= brightness;
      s1_prod_ff       <= prod_in;

      s2_meta_ff   <= s1_meta_ff;
      s2_src_ff    <= s1_src_ff;
      s2_bright_ff <= s1_bright_ff;
      s2_alpha_ff  <= pdab_pkg::div255(s1_prod_ff);
   end

   assign out_valid  = s2_valid_ff;
   assign meta_out   = s2_meta_ff;
   assign src_out    = s2_src_ff;
   assign alpha_out  = s2_alpha_ff;
   assign bright_out = s2_bright_ff;

endmodule

`default_nettype wire

FILE: rtl/pdab_chan.sv
// One color channel: (dst*(255-a) + src*a*br/32767) / 255, five stages.
`default_nettype none

module pdab_chan (
   input  wire logic                               clock,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]    dst,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]    src,
   input  wire logic [pdab_pkg::COLOR_BITS-1:0]    alpha,
   input  wire logic [pdab_pkg::BRIGHT_BITS-1:0]   bright,
   output logic [pdab_pkg::COLOR_BITS-1:0]         mix
);

   logic [15:0]                       s3_sa_ff;
   logic [15:0]                       s3_db_ff;
   logic [pdab_pkg::BRIGHT_BITS-1:0]  s3_br_ff;
   logic [30:0]                       s4_y_ff;
   logic [15:0]                       s4_db_ff;
   logic [15:0]                       s5_q_ff;
   logic [15:0]                       s5_db_ff;
   logic [15:0]                       s6_sum_ff;
   logic [pdab_pkg::COLOR_BITS-1:0]   s7_mix_ff;

   // the sum never exceeds 255*255, so 16 bits hold it
   always_ff @(posedge clock) begin
      s3_sa_ff  <= {8'b0, src} * {8'b0, alpha};
      s3_db_ff  <= {8'b0, dst} * {8'b0, pdab_pkg::ALPHA_FULL - alpha};
      s3_br_ff  <= bright;
      s4_y_ff   <= 31'(s3_sa_ff) * 31'(s3_br_ff);
      s4_db_ff  <= s3_db_ff;
      s5_q_ff   <= pdab_pkg::div32767(s4_y_ff);
      s5_db_ff  <= s4_db_ff;
      s6_sum_ff <= s5_db_ff + s5_q_ff;
      s7_mix_ff <= pdab_pkg::div255(s6_sum_ff);
   end

   assign mix = s7_mix_ff;

endmodule

`default_nettype wire

FILE: rtl/pdab_checker.sv
// Port-level checks for the blend stage, bound to the top level.
`default_nettype none

module pdab_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic [pdab_pkg::COLOR_BITS-1:0]     req_dst_red,
   input wire logic [pdab_pkg::COLOR_BITS-1:0]     req_src_alpha,
   input wire logic [pdab_pkg::DEPTH_BITS-1:0]     req_stored_depth,
   input wire logic [pdab_pkg::BRIGHT_BITS-1:0]    req_brightness,
   input wire logic                                rsp_strobe,
   input wire logic [pdab_pkg::COLOR_BITS-1:0]     rsp_out_red,
   input wire logic [pdab_pkg::DEPTH_BITS-1:0]     rsp_out_depth,
   input wire logic                                rsp_color_written
);

   // every request beat returns a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(pdab_pkg::LATENCY) rsp_strobe)
      else $error("request beat without result");

   // rejected fragment hands back the framebuffer color (red channel checked)
   a_reject_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_color_written) |->
         (rsp_out_red == $past(req_dst_red, pdab_pkg::LATENCY)))
      else $error("rejected fragment changed color");

   // rejected fragment keeps the stored depth
   a_reject_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_color_written) |->
         (rsp_out_depth == $past(req_stored_depth, pdab_pkg::LATENCY)))
      else $error("rejected fragment changed depth");

   // a written fragment had nonzero brightness and alpha
   a_pass_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_color_written) |->
         (($past(req_brightness, pdab_pkg::LATENCY) != '0) &&
          ($past(req_src_alpha, pdab_pkg::LATENCY) != '0)))
      else $error("fragment written with zero brightness or alpha");

endmodule

bind pixel_depth_alpha_blend_top pdab_checker u_pdab_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_dst_red       (req_dst_red),
   .req_src_alpha     (req_src_alpha),
   .req_stored_depth  (req_stored_depth),
   .req_brightness    (req_brightness),
   .rsp_strobe        (rsp_strobe),
   .rsp_out_red       (rsp_out_red),
   .rsp_out_depth     (rsp_out_depth),
   .rsp_color_written (rsp_color_written)
);

`default_nettype wire
